>>> hdl/swht_pkg.sv
// Shared constants and types of the segment window hit test unit.
package swht_pkg;

   // Configuration register indexes.
   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_MIN_X = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_MIN_Y = 2'd1;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_MAX_X = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] REG_WINDOW_MAX_Y = 2'd3;

   // Width of the result word: the hit flag padded to one byte.
   localparam int RSP_DATA_WIDTH = 8;

   // Outcome of the cheap tests that settle an item without the products.
   typedef struct packed {
      logic decided;
      logic hit;
   } early_type;

endpackage

>>> hdl/swht_mul.sv
// Two-stage signed multiplier built from four half-width partial products.
module swht_mul #(
   parameter int OPER_WIDTH = 33
) (
   input  logic                             clock,
   input  logic                             enable,
   input  logic signed [OPER_WIDTH-1:0]     a,
   input  logic signed [OPER_WIDTH-1:0]     b,
   output logic signed [2*OPER_WIDTH-1:0]   product
);
   localparam int LOW_W     = (OPER_WIDTH + 1) / 2;
   localparam int PART_IN_W = LOW_W + 1;
   localparam int PART_W    = 2 * PART_IN_W;
   localparam int PROD_W    = 2 * OPER_WIDTH;

   logic signed [PART_IN_W-1:0] a_lo, a_hi, b_lo, b_hi;
   logic signed [PART_W-1:0]    ll_in, lh_in, hl_in, hh_in;
   logic signed [PART_W-1:0]    ll_ff, lh_ff, hl_ff, hh_ff;
   logic signed [PROD_W-1:0]    mid;
   logic signed [PROD_W-1:0]    product_in, product_ff;

   // Split each operand into an unsigned low half and a signed high half.
   assign a_lo = signed'({1'b0, a[LOW_W-1:0]});
   assign b_lo = signed'({1'b0, b[LOW_W-1:0]});
   assign a_hi = PART_IN_W'(signed'(a[OPER_WIDTH-1:LOW_W]));
   assign b_hi = PART_IN_W'(signed'(b[OPER_WIDTH-1:LOW_W]));

   // First stage: the four partial products.
   assign ll_in = PART_W'(a_lo) * PART_W'(b_lo);
   assign lh_in = PART_W'(a_lo) * PART_W'(b_hi);
   assign hl_in = PART_W'(a_hi) * PART_W'(b_lo);
   assign hh_in = PART_W'(a_hi) * PART_W'(b_hi);

   always_ff @(posedge clock) begin
      if (enable) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
         hh_ff <= hh_in;
      end
   end

   // Second stage: weight and add the partial products.
   assign mid        = PROD_W'(lh_ff) + PROD_W'(hl_ff);
   assign product_in = (PROD_W'(hh_ff) <<< (2 * LOW_W)) + (mid <<< LOW_W) + PROD_W'(ll_ff);

   always_ff @(posedge clock) begin
      if (enable) begin
         product_ff <= product_in;
      end
   end

   assign product = product_ff;

endmodule

>>> hdl/segment_window_hit_test_unit.sv
// Top level of the segment window hit test unit: a five-stage pipeline.
//
//  Channel  Direction  Handshake              Payload
//  req_     in         req_tvalid/req_tready  segment endpoints, one word per segment
//  rsp_     out        rsp_tvalid/rsp_tready  hit flag, one word per segment
//  csr_     in         csr_wen                window edge register write
//
// One segment enters per cycle unless the output waits; its flag leaves stage five.
// The depth is set by the split multipliers, which take two stages each.
// Reset clears the valid bits and the window registers; the window resets to all zero.
// All stages hold together while the output word waits; ready then drops to low.
module segment_window_hit_test_unit #(
   parameter int COORD_WIDTH = 32
) (
   input  logic                                     clock,
   input  logic                                     reset,
   // Fields from bit 0 up: start_x, start_y, end_x, end_y, zero padding.
   input  logic                                     req_tvalid,
   output logic                                     req_tready,
   input  logic [((4*COORD_WIDTH+7)/8)*8-1:0]       req_tdata,
   // Fields from bit 0 up: hit, zero padding.
   output logic                                     rsp_tvalid,
   input  logic                                     rsp_tready,
   output logic [swht_pkg::RSP_DATA_WIDTH-1:0]      rsp_tdata,
   input  logic                                     csr_wen,
   input  logic [swht_pkg::CSR_INDEX_WIDTH-1:0]     csr_index,
   input  logic [COORD_WIDTH-1:0]                   csr_wdata
);
   import swht_pkg::*;

   localparam int W     = COORD_WIDTH;
   localparam int OW    = COORD_WIDTH + 1;
   localparam int EW    = COORD_WIDTH + 2;
   localparam int PW    = 2 * OW;
   localparam int NPROD = 8;

   // Window registers.
   logic signed [W-1:0] win_min_x_ff, win_min_y_ff, win_max_x_ff, win_max_y_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_min_x_ff <= '0;
         win_min_y_ff <= '0;
         win_max_x_ff <= '0;
         win_max_y_ff <= '0;
      end else if (csr_wen) begin
         unique case (csr_index)
            REG_WINDOW_MIN_X: win_min_x_ff <= signed'(csr_wdata);
            REG_WINDOW_MIN_Y: win_min_y_ff <= signed'(csr_wdata);
            REG_WINDOW_MAX_X: win_max_x_ff <= signed'(csr_wdata);
            REG_WINDOW_MAX_Y: win_max_y_ff <= signed'(csr_wdata);
            default: ;
         endcase
      end
   end

   // The whole pipeline moves when the output register is free or being taken.
   logic adv;
   logic s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff, out_valid_ff;
   logic out_hit_ff, out_hit_in;

   assign adv        = !out_valid_ff || rsp_tready;
   assign req_tready = adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= s1_valid_ff;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         out_valid_ff <= s4_valid_ff;
      end
   end

   // Stage one: register the endpoints.
   logic signed [W-1:0] s1_x1_ff, s1_y1_ff, s1_x2_ff, s1_y2_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_x1_ff <= signed'(req_tdata[W-1:0]);
         s1_y1_ff <= signed'(req_tdata[2*W-1:W]);
         s1_x2_ff <= signed'(req_tdata[3*W-1:2*W]);
         s1_y2_ff <= signed'(req_tdata[4*W-1:3*W]);
      end
   end

   // Stage two: runs, their magnitudes, sign-adjusted rises, edge offsets and the box.
   logic signed [OW-1:0] dx_in, dy_in, adx_in, sdy_in, ady_in, sdx_in;
   logic signed [OW-1:0] ex0_in, ex1_in, ey0_in, ey1_in;
   logic signed [W-1:0]  xmin_in, xmax_in, ymin_in, ymax_in;

   always_comb begin
      dx_in   = OW'(s1_x2_ff) - OW'(s1_x1_ff);
      dy_in   = OW'(s1_y2_ff) - OW'(s1_y1_ff);
      adx_in  = dx_in[OW-1] ? -dx_in : dx_in;
      sdy_in  = dx_in[OW-1] ? -dy_in : dy_in;
      ady_in  = dy_in[OW-1] ? -dy_in : dy_in;
      sdx_in  = dy_in[OW-1] ? -dx_in : dx_in;
      ex0_in  = OW'(win_min_x_ff) - OW'(s1_x1_ff);
      ex1_in  = OW'(win_max_x_ff) - OW'(s1_x1_ff);
      ey0_in  = OW'(win_min_y_ff) - OW'(s1_y1_ff);
      ey1_in  = OW'(win_max_y_ff) - OW'(s1_y1_ff);
      xmin_in = (s1_x1_ff < s1_x2_ff) ? s1_x1_ff : s1_x2_ff;
      xmax_in = (s1_x1_ff < s1_x2_ff) ? s1_x2_ff : s1_x1_ff;
      ymin_in = (s1_y1_ff < s1_y2_ff) ? s1_y1_ff : s1_y2_ff;
      ymax_in = (s1_y1_ff < s1_y2_ff) ? s1_y2_ff : s1_y1_ff;
   end

   logic signed [OW-1:0] s2_dx_ff, s2_dy_ff, s2_adx_ff, s2_sdy_ff, s2_ady_ff, s2_sdx_ff;
   logic signed [OW-1:0] s2_ex0_ff, s2_ex1_ff, s2_ey0_ff, s2_ey1_ff;
   logic signed [W-1:0]  s2_x1_ff, s2_y1_ff;
   logic signed [W-1:0]  s2_xmin_ff, s2_xmax_ff, s2_ymin_ff, s2_ymax_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_dx_ff   <= dx_in;
         s2_dy_ff   <= dy_in;
         s2_adx_ff  <= adx_in;
         s2_sdy_ff  <= sdy_in;
         s2_ady_ff  <= ady_in;
         s2_sdx_ff  <= sdx_in;
         s2_ex0_ff  <= ex0_in;
         s2_ex1_ff  <= ex1_in;
         s2_ey0_ff  <= ey0_in;
         s2_ey1_ff  <= ey1_in;
         s2_x1_ff   <= s1_x1_ff;
         s2_y1_ff   <= s1_y1_ff;
         s2_xmin_ff <= xmin_in;
         s2_xmax_ff <= xmax_in;
         s2_ymin_ff <= ymin_in;
         s2_ymax_ff <= ymax_in;
      end
   end

   // Stage three: box, axis-parallel and diagonal tests settle many segments early.
   logic                 reject, accept, vert, horiz, diag_pos, diag_neg;
   logic                 vert_hit, horiz_hit, diag_hit;
   logic signed [EW-1:0] ya, yb, xa, xb;
   early_type            early_in, s3_early_ff, s4_early_ff;

   always_comb begin
      reject    = (s2_xmax_ff < win_min_x_ff) || (s2_xmin_ff > win_max_x_ff) ||
                  (s2_ymax_ff < win_min_y_ff) || (s2_ymin_ff > win_max_y_ff);
      accept    = (s2_xmax_ff < win_max_x_ff) && (s2_xmin_ff > win_min_x_ff) &&
                  (s2_ymax_ff < win_max_y_ff) && (s2_ymin_ff > win_min_y_ff);
      vert      = (s2_xmin_ff == s2_xmax_ff);
      horiz     = (s2_ymin_ff == s2_ymax_ff);
      vert_hit  = (s2_xmin_ff > win_min_x_ff) && (s2_xmin_ff < win_max_x_ff) &&
                  (s2_ymax_ff > win_min_y_ff) && (s2_ymin_ff < win_max_y_ff);
      horiz_hit = (s2_ymin_ff > win_min_y_ff) && (s2_ymin_ff < win_max_y_ff) &&
                  (s2_xmax_ff > win_min_x_ff) && (s2_xmin_ff < win_max_x_ff);
      diag_pos  = (s2_dx_ff == s2_dy_ff);
      diag_neg  = ((EW'(s2_dx_ff) + EW'(s2_dy_ff)) == '0);
      // Intercepts of a 45-degree line on the four window edges.
      if (diag_pos) begin
         ya = EW'(s2_ex0_ff) + EW'(s2_y1_ff);
         yb = EW'(s2_ex1_ff) + EW'(s2_y1_ff);
         xa = EW'(s2_ey0_ff) + EW'(s2_x1_ff);
         xb = EW'(s2_ey1_ff) + EW'(s2_x1_ff);
      end else begin
         ya = EW'(s2_y1_ff) - EW'(s2_ex0_ff);
         yb = EW'(s2_y1_ff) - EW'(s2_ex1_ff);
         xa = EW'(s2_x1_ff) - EW'(s2_ey0_ff);
         xb = EW'(s2_x1_ff) - EW'(s2_ey1_ff);
      end
      diag_hit = ((ya > EW'(win_min_y_ff)) && (ya < EW'(win_max_y_ff))) ||
                 ((yb > EW'(win_min_y_ff)) && (yb < EW'(win_max_y_ff))) ||
                 ((xa > EW'(win_min_x_ff)) && (xa < EW'(win_max_x_ff))) ||
                 ((xb > EW'(win_min_x_ff)) && (xb < EW'(win_max_x_ff)));
      early_in.decided = reject || accept || vert || horiz || diag_pos || diag_neg;
      if (reject) begin
         early_in.hit = 1'b0;
      end else if (accept) begin
         early_in.hit = 1'b1;
      end else if (vert) begin
         early_in.hit = vert_hit;
      end else if (horiz) begin
         early_in.hit = horiz_hit;
      end else begin
         early_in.hit = diag_hit;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_early_ff <= early_in;
         s4_early_ff <= s3_early_ff;
      end
   end

   // Stages three and four: cross products for the exact intercept tests.
   // Order: t on left, right, bottom, top side; low and high bounds for x then y sides.
   logic signed [OW-1:0] mul_a [NPROD];
   logic signed [OW-1:0] mul_b [NPROD];
   logic signed [PW-1:0] prod  [NPROD];

   always_comb begin
      mul_a[0] = s2_ex0_ff;  mul_b[0] = s2_sdy_ff;
      mul_a[1] = s2_ex1_ff;  mul_b[1] = s2_sdy_ff;
      mul_a[2] = s2_ey0_ff;  mul_b[2] = s2_sdx_ff;
      mul_a[3] = s2_ey1_ff;  mul_b[3] = s2_sdx_ff;
      mul_a[4] = s2_ey0_ff;  mul_b[4] = s2_adx_ff;
      mul_a[5] = s2_ey1_ff;  mul_b[5] = s2_adx_ff;
      mul_a[6] = s2_ex0_ff;  mul_b[6] = s2_ady_ff;
      mul_a[7] = s2_ex1_ff;  mul_b[7] = s2_ady_ff;
   end

   for (genvar g = 0; g < NPROD; g++) begin : g_mul
      swht_mul #(
         .OPER_WIDTH (OW)
      ) u_mul (
         .clock   (clock),
         .enable  (adv),
         .a       (mul_a[g]),
         .b       (mul_b[g]),
         .product (prod[g])
      );
   end

   // Stage five: strict intercept compares and the final flag.
   logic cross_hit;

   always_comb begin
      cross_hit = ((prod[4] < prod[0]) && (prod[0] < prod[5])) ||
                  ((prod[4] < prod[1]) && (prod[1] < prod[5])) ||
                  ((prod[6] < prod[2]) && (prod[2] < prod[7])) ||
                  ((prod[6] < prod[3]) && (prod[3] < prod[7]));
      out_hit_in = s4_early_ff.decided ? s4_early_ff.hit : cross_hit;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_hit_ff <= out_hit_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_WIDTH-1){1'b0}}, out_hit_ff};

   // An accepted word is held in stage one on the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> s1_valid_ff)
      else $error("accepted word missing from stage one");

   // A held output stalls every stage, so nothing moves inside the pipeline.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(s4_valid_ff) && $stable(s3_valid_ff)))
      else $error("pipeline moved during a stall");

   // A segment settled by the early tests leaves with the early flag.
   assert property (@(posedge clock) disable iff (reset)
      (s4_valid_ff && adv && s4_early_ff.decided) |=>
         (rsp_tvalid && (rsp_tdata[0] == $past(s4_early_ff.hit))))
      else $error("early decision lost on the way out");

   // A segment rejected by its box never reports a hit.
   assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && adv && reject) |=> !s3_early_ff.hit)
      else $error("rejected segment flagged as hit");

endmodule

>>> verif/tb_top.sv
// Testbench of the segment window hit test unit: stream driver, result checker and stimulus.
`timescale 1ns / 100ps

module tb_top;
   import swht_pkg::*;

   localparam int COORD_WIDTH = 32;
   localparam int REQ_DATA_WIDTH = ((4*COORD_WIDTH+7)/8)*8;
   localparam longint COORD_MIN = -64'sd2147483648;
   localparam longint COORD_MAX = 64'sd2147483647;
   localparam int PHASE_COUNT = 12;
   localparam int PHASE_ITEMS = 140;

   // One segment as it travels in a request word; start_x sits in the lowest bits.
   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] end_y;
      logic signed [COORD_WIDTH-1:0] end_x;
      logic signed [COORD_WIDTH-1:0] start_y;
      logic signed [COORD_WIDTH-1:0] start_x;
   } segment_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   // Fields from bit 0 up: start_x, start_y, end_x, end_y.
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [REQ_DATA_WIDTH-1:0]    req_tdata = '0;
   // Fields from bit 0 up: hit, zero padding.
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [RSP_DATA_WIDTH-1:0]    rsp_tdata;
   logic                         csr_wen = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0]   csr_index = '0;
   logic [COORD_WIDTH-1:0]       csr_wdata = '0;

   // Our copy of the window registers, indexed by register code.
   logic signed [COORD_WIDTH-1:0] window_edge [4] = '{default: '0};

   segment_type segment_queue [$];
   bit       expected_hits [$];
   int       error_count = 0;
   int       results_seen = 0;
   bit       idling_on = 1'b0;
   int       send_gap = 0;
   int       stall_left = 0;
   bit       long_stall_done = 1'b0;

   segment_window_hit_test_unit #(.COORD_WIDTH(COORD_WIDTH)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- prediction

   function automatic bit strictly_between(longint v, longint lo, longint hi);
      return v > lo && v < hi;
   endfunction

   // Does the line cross the edge at edge_pos strictly between lo and hi?
   // Both sides are scaled by the run so that the test stays exact.
   function automatic bit intercept_inside(longint edge_pos, longint p1, longint q1,
                                           longint dp, longint dq, longint lo, longint hi);
      logic signed [127:0] run, rise, offset, lo_off, hi_off, cross_prod, lo_cross, hi_cross;
      run = 128'((dp < 0) ? -dp : dp);
      rise = 128'((dp < 0) ? -dq : dq);
      offset = 128'(edge_pos - p1);
      lo_off = 128'(lo - q1);
      hi_off = 128'(hi - q1);
      cross_prod = offset * rise;
      lo_cross = lo_off * run;
      hi_cross = hi_off * run;
      return lo_cross < cross_prod && cross_prod < hi_cross;
   endfunction

   function automatic bit predict_hit(segment_type seg);
      longint x1, y1, x2, y2, wx0, wy0, wx1, wy1;
      longint xmin, xmax, ymin, ymax, dx, dy, ya, yb, xa, xb;
      x1 = longint'(seg.start_x);
      y1 = longint'(seg.start_y);
      x2 = longint'(seg.end_x);
      y2 = longint'(seg.end_y);
      wx0 = longint'(window_edge[REG_WINDOW_MIN_X]);
      wy0 = longint'(window_edge[REG_WINDOW_MIN_Y]);
      wx1 = longint'(window_edge[REG_WINDOW_MAX_X]);
      wy1 = longint'(window_edge[REG_WINDOW_MAX_Y]);
      xmin = (x1 < x2) ? x1 : x2;
      xmax = (x1 < x2) ? x2 : x1;
      ymin = (y1 < y2) ? y1 : y2;
      ymax = (y1 < y2) ? y2 : y1;

      // Bounding box entirely outside, or strictly inside.
      if (xmax < wx0 || xmin > wx1 || ymax < wy0 || ymin > wy1)
         return 1'b0;
      if (xmax < wx1 && xmin > wx0 && ymax < wy1 && ymin > wy0)
         return 1'b1;
      // Vertical and horizontal lines, a single point included in the first.
      if (xmin == xmax)
         return strictly_between(xmin, wx0, wx1) && ymax > wy0 && ymin < wy1;
      if (ymin == ymax)
         return strictly_between(ymin, wy0, wy1) && xmax > wx0 && xmin < wx1;

      dx = x2 - x1;
      dy = y2 - y1;
      // Lines at 45 degrees have integer intercepts.
      if (dx == dy || dx == -dy) begin
         if (dx == dy) begin
            ya = wx0 - x1 + y1;
            yb = wx1 - x1 + y1;
            xa = wy0 - y1 + x1;
            xb = wy1 - y1 + x1;
         end else begin
            ya = x1 + y1 - wx0;
            yb = x1 + y1 - wx1;
            xa = x1 + y1 - wy0;
            xb = x1 + y1 - wy1;
         end
         return strictly_between(ya, wy0, wy1) || strictly_between(yb, wy0, wy1) ||
                strictly_between(xa, wx0, wx1) || strictly_between(xb, wx0, wx1);
      end

      return intercept_inside(wx0, x1, y1, dx, dy, wy0, wy1) ||
             intercept_inside(wx1, x1, y1, dx, dy, wy0, wy1) ||
             intercept_inside(wy0, y1, x1, dy, dx, wx0, wx1) ||
             intercept_inside(wy1, y1, x1, dy, dx, wx0, wx1);
   endfunction

   // ---------------------------------------------------------------- driver

   // Offer the next segment, after any idle gap, whenever the current word has gone or none is up.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            expected_hits.push_back(predict_hit(segment_type'(req_tdata)));
         if (!req_tvalid || req_tready) begin
            if (send_gap > 0) begin
               send_gap = send_gap - 1;
               req_tvalid <= 1'b0;
            end else if (segment_queue.size() > 0) begin
               req_tdata <= segment_queue.pop_front();
               req_tvalid <= 1'b1;
               if (idling_on && $urandom_range(0, 7) == 0)
                  send_gap = $urandom_range(1, 19);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   task automatic report_mismatch(string what);
      if (error_count < 40)
         $display("tb: mismatch at result %0d: %s", results_seen, what);
      error_count = error_count + 1;
   endtask

   // Check each result word against the oldest prediction and pace rsp_tready.
   always @(posedge clock) begin
      bit hit_expected;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_hits.size() == 0) begin
               report_mismatch("result word with no segment outstanding");
            end else begin
               hit_expected = expected_hits.pop_front();
               if (rsp_tdata[0] !== hit_expected)
                  report_mismatch($sformatf("hit %b, expected %b", rsp_tdata[0], hit_expected));
            end
            results_seen = results_seen + 1;
         end
         // One long hold-off while the sender still has plenty queued fills the pipeline.
         if (stall_left > 0) begin
            stall_left = stall_left - 1;
            rsp_tready <= 1'b0;
         end else if (!long_stall_done && results_seen > 200 && segment_queue.size() > 30) begin
            long_stall_done = 1'b1;
            stall_left = 300;
            rsp_tready <= 1'b0;
         end else if (idling_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 19) - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------- stimulus helpers

   function automatic logic signed [COORD_WIDTH-1:0] to_coord(longint v);
      if (v < COORD_MIN)
         v = COORD_MIN;
      if (v > COORD_MAX)
         v = COORD_MAX;
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic longint random_coord();
      return longint'(int'($urandom));
   endfunction

   // A coordinate in or around the span between a and b.
   function automatic longint near_coord(longint a, longint b);
      longint lo, hi, margin, span;
      longint unsigned pick;
      lo = (a < b) ? a : b;
      hi = (a < b) ? b : a;
      case ($urandom_range(0, 3))
         0: margin = longint'($urandom_range(0, 3));
         1: margin = longint'($urandom_range(0, 64));
         default: margin = (hi - lo) / 2 + 1;
      endcase
      lo = lo - margin;
      hi = hi + margin;
      span = hi - lo + 1;
      pick = {$urandom, $urandom};
      return longint'(to_coord(lo + longint'(pick % longint'(span))));
   endfunction

   // A coordinate on or next to the bound a or the bound b.
   function automatic longint edge_coord(longint a, longint b);
      longint base;
      base = $urandom_range(0, 1) ? a : b;
      return longint'(to_coord(base + longint'($urandom_range(0, 2)) - 1));
   endfunction

   function automatic segment_type random_segment();
      segment_type seg;
      longint wx0, wy0, wx1, wy1, x1, y1, x2, y2;
      wx0 = longint'(window_edge[REG_WINDOW_MIN_X]);
      wy0 = longint'(window_edge[REG_WINDOW_MIN_Y]);
      wx1 = longint'(window_edge[REG_WINDOW_MAX_X]);
      wy1 = longint'(window_edge[REG_WINDOW_MAX_Y]);
      x1 = near_coord(wx0, wx1);
      y1 = near_coord(wy0, wy1);
      x2 = near_coord(wx0, wx1);
      y2 = near_coord(wy0, wy1);
      case ($urandom_range(0, 9))
         0: begin
            x1 = random_coord();
            y1 = random_coord();
            x2 = random_coord();
            y2 = random_coord();
         end
         4: begin
            if ($urandom_range(0, 1))
               x1 = edge_coord(wx0, wx1);
            x2 = x1;
         end
         5: begin
            if ($urandom_range(0, 1))
               y1 = edge_coord(wy0, wy1);
            y2 = y1;
         end
         6: y2 = y1 + (x2 - x1);
         7: y2 = y1 - (x2 - x1);
         8: begin
            x2 = x1;
            y2 = y1;
         end
         9: begin
            x1 = edge_coord(wx0, wx1);
            y1 = edge_coord(wy0, wy1);
            x2 = edge_coord(wx0, wx1);
            y2 = edge_coord(wy0, wy1);
         end
         default: ;
      endcase
      seg.start_x = to_coord(x1);
      seg.start_y = to_coord(y1);
      seg.end_x = to_coord(x2);
      seg.end_y = to_coord(y2);
      return seg;
   endfunction

   task automatic add_segment(longint x1, longint y1, longint x2, longint y2);
      segment_type seg;
      seg.start_x = to_coord(x1);
      seg.start_y = to_coord(y1);
      seg.end_x = to_coord(x2);
      seg.end_y = to_coord(y2);
      segment_queue.push_back(seg);
   endtask

   // Hold the sender until every queued segment has been answered.
   // The check runs at the falling edge, when the driver and the checker have settled.
   task automatic wait_drained();
      do
         @(negedge clock);
      while (segment_queue.size() != 0 || req_tvalid || expected_hits.size() != 0);
   endtask

   task automatic write_window_reg(logic [CSR_INDEX_WIDTH-1:0] index, longint value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= index;
      csr_wdata <= to_coord(value);
      window_edge[index] = to_coord(value);
   endtask

   task automatic program_window(longint x0, longint y0, longint x1, longint y1);
      write_window_reg(REG_WINDOW_MIN_X, x0);
      write_window_reg(REG_WINDOW_MIN_Y, y0);
      write_window_reg(REG_WINDOW_MAX_X, x1);
      write_window_reg(REG_WINDOW_MAX_Y, y1);
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   // Window shapes: full range, small, medium, large, inverted, thin and cornered.
   task automatic program_random_window(int shape);
      longint ax, bx, ay, by, swap_tmp;
      case (shape)
         0: begin
            ax = COORD_MIN;
            ay = COORD_MIN;
            bx = COORD_MAX;
            by = COORD_MAX;
         end
         1: begin
            ax = random_coord();
            ay = random_coord();
            bx = ax + longint'($urandom_range(1, 2000));
            by = ay + longint'($urandom_range(1, 2000));
         end
         2: begin
            ax = longint'($urandom_range(0, 2097152)) - 1048576;
            ay = longint'($urandom_range(0, 2097152)) - 1048576;
            bx = ax + longint'($urandom_range(1, 1048576));
            by = ay + longint'($urandom_range(1, 1048576));
         end
         5: begin
            ax = longint'($urandom_range(0, 20000)) - 10000;
            ay = longint'($urandom_range(0, 20000)) - 10000;
            bx = ax + longint'($urandom_range(0, 2));
            by = ay + longint'($urandom_range(1, 5000));
            if ($urandom_range(0, 1)) begin
               swap_tmp = bx - ax;
               bx = ax + (by - ay);
               by = ay + swap_tmp;
            end
         end
         6: begin
            if ($urandom_range(0, 1)) begin
               ax = COORD_MIN;
               bx = COORD_MIN + longint'($urandom_range(1, 1000));
            end else begin
               bx = COORD_MAX;
               ax = COORD_MAX - longint'($urandom_range(1, 1000));
            end
            if ($urandom_range(0, 1)) begin
               ay = COORD_MIN;
               by = COORD_MIN + longint'($urandom_range(1, 1000));
            end else begin
               by = COORD_MAX;
               ay = COORD_MAX - longint'($urandom_range(1, 1000));
            end
         end
         default: begin
            ax = random_coord();
            bx = random_coord();
            ay = random_coord();
            by = random_coord();
            if (ax > bx) begin
               swap_tmp = ax;
               ax = bx;
               bx = swap_tmp;
            end
            if (ay > by) begin
               swap_tmp = ay;
               ay = by;
               by = swap_tmp;
            end
            // The inverted shape flips x and maybe y as well.
            if (shape == 4) begin
               swap_tmp = ax;
               ax = bx;
               bx = swap_tmp;
               if ($urandom_range(0, 1)) begin
                  swap_tmp = ay;
                  ay = by;
                  by = swap_tmp;
               end
            end
         end
      endcase
      program_window(ax, ay, bx, by);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin : stimulus
      int phase;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Window still at its reset value, all edges zero.
      add_segment(0, 0, 0, 0);
      add_segment(-5, -5, 5, 5);
      wait_drained();

      // Square window around the origin.
      program_window(-100, -100, 100, 100);
      add_segment(-300, -50, -150, 50);
      add_segment(150, -50, 300, 50);
      add_segment(-50, 150, 50, 300);
      add_segment(-50, -300, 50, -150);
      add_segment(-20, -30, 40, 60);
      add_segment(0, -200, 0, 200);
      add_segment(-100, -200, -100, 200);
      add_segment(-200, 50, 200, 50);
      add_segment(-200, 100, 200, 100);
      add_segment(0, 0, 0, 0);
      add_segment(100, 0, 100, 0);
      add_segment(-200, -200, 200, 200);
      add_segment(-200, 200, 200, -200);
      add_segment(100, 100, 200, 200);
      add_segment(-200, -50, 200, 30);
      add_segment(150, -300, 300, 150);
      wait_drained();

      // Full-range window with segments at the coordinate extremes.
      program_window(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      add_segment(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX);
      add_segment(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN);
      add_segment(COORD_MIN, COORD_MIN + 5, COORD_MAX, COORD_MAX - 7);
      add_segment(COORD_MIN, COORD_MIN, COORD_MIN, COORD_MAX);
      wait_drained();

      // Inverted window, min above max on both axes.
      program_window(100, 100, -100, -100);
      add_segment(0, 0, 0, 0);
      add_segment(-200, -150, 200, 170);
      wait_drained();

      // Random phases, each under its own window; every third phase and the last three run without idling.
      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         program_random_window((phase < 7) ? phase : $urandom_range(0, 6));
         idling_on = (phase < PHASE_COUNT - 3) && (phase % 3 != 2);
         repeat (PHASE_ITEMS)
            segment_queue.push_back(random_segment());
         wait_drained();
      end
      idling_on = 1'b0;

      repeat (20) @(posedge clock);
      if (error_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

   // Guard against a hung handshake.
   initial begin : watchdog
      #5000000;
      $display("tb: failure");
      $finish;
   end

endmodule
